// File: hdl/abpt_pkg.sv
// Shared types, character codes and the byte classifier for the pre-tokenizer.
`timescale 1ns / 1ps

package abpt_pkg;

  typedef enum logic [1:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_SYMBOL,
    CLS_SPACE
  } cls_t;

  typedef struct packed {
    logic [6:0] data;
    logic       tok_end;
    logic       bad_input;
    logic       batch_last;
  } res_t;

  typedef struct packed {
    logic room;
    logic avail;
  } resq_stat_t;

  localparam int ResqDepth = 8;
  localparam int ResqPtrW  = $clog2(ResqDepth);
  localparam int ResqCntW  = ResqPtrW + 1;
  localparam int MaxPush   = 3;
  localparam int PushCntW  = 2;

  localparam logic [6:0] CH_QUOTE = 7'h27;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_LO_S  = 7'h73;
  localparam logic [6:0] CH_LO_T  = 7'h74;
  localparam logic [6:0] CH_LO_M  = 7'h6d;
  localparam logic [6:0] CH_LO_D  = 7'h64;
  localparam logic [6:0] CH_LO_R  = 7'h72;
  localparam logic [6:0] CH_LO_V  = 7'h76;
  localparam logic [6:0] CH_LO_L  = 7'h6c;
  localparam logic [6:0] CH_LO_E  = 7'h65;

  function automatic cls_t byte_cls(input logic [6:0] b);
    cls_t c;
    if ((b >= 7'h41 && b <= 7'h5a) || (b >= 7'h61 && b <= 7'h7a)) begin
      c = CLS_LETTER;
    end else if (b >= 7'h30 && b <= 7'h39) begin
      c = CLS_DIGIT;
    end else if (b == CH_SPACE || (b >= 7'h09 && b <= 7'h0d)) begin
      c = CLS_SPACE;
    end else begin
      c = CLS_SYMBOL;
    end
    return c;
  endfunction

endpackage

// File: hdl/abpt_resq.sv
// Result queue: takes up to three words per cycle, delivers one per cycle.
`timescale 1ns / 1ps

module abpt_resq
  import abpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PushCntW-1:0] push_n,
  input  res_t                push_d [MaxPush],
  input  logic                pop,
  output res_t                head,
  output resq_stat_t          stat
);

  res_t                mem_r [ResqDepth];
  logic [ResqPtrW-1:0] wr_r;
  logic [ResqPtrW-1:0] rd_r;
  logic [ResqCntW-1:0] cnt_r;
  logic                pop_ok;

  assign pop_ok     = pop && (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign stat.avail = (cnt_r != '0);
  assign stat.room  = (cnt_r <= ResqCntW'(ResqDepth - MaxPush));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + ResqPtrW'(push_n);
      rd_r  <= rd_r + ResqPtrW'(pop_ok);
      cnt_r <= cnt_r + ResqCntW'(push_n) - ResqCntW'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MaxPush; i++) begin
      if (PushCntW'(i) < push_n) begin
        mem_r[wr_r + ResqPtrW'(i)] <= push_d[i];
      end
    end
  end

endmodule

// File: hdl/ascii_bpe_pretokenizer_unit.sv
// ASCII pre-tokenizer top level: byte classifier, contraction matcher, piece splitter.
// A taken word is registered at the input stage, then its results are written into the queue that drives out_.
// Throughput: one text word per cycle unless stalled; results leave one per cycle from an 8-entry queue.
// Input stalls while fewer than three queue entries are free; up to two bytes are held.
// Reset: synchronous, active low; clears piece state, reject flag and the queue.
`timescale 1ns / 1ps

module ascii_bpe_pretokenizer_unit
  import abpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_text_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_byte,
  output logic       out_tok_end,
  output logic       out_bad_input,
  output logic       out_batch_last
);

  typedef enum logic [2:0] {
    ST_EMPTY,
    ST_RUN,
    ST_SP1,
    ST_SP2,
    ST_NSP,
    ST_NQ,
    ST_NQR
  } st_t;

  st_t                 st_r, st_nxt;
  logic                latch_r, latch_nxt;
  logic                in_vld_r;
  logic [7:0]          in_byte_r;
  logic                in_last_r;
  logic [6:0]          h0_r, h0_nxt;
  logic [6:0]          h1_r, h1_nxt;
  cls_t                cls_r, cls_nxt;
  logic                fire;
  logic [6:0]          x;
  cls_t                xc;
  st_t                 s_st;
  logic [6:0]          want;
  logic                go_start;
  logic [PushCntW-1:0] idx;
  res_t                push_d [MaxPush];
  logic [PushCntW-1:0] push_n;
  res_t                head;
  resq_stat_t          stat;

  function automatic res_t mk(input logic [6:0] v, input logic e);
    res_t r;
    r.data       = v;
    r.tok_end    = e;
    r.bad_input  = 1'b0;
    r.batch_last = 1'b0;
    return r;
  endfunction

  assign fire     = in_vld_r && stat.room;
  assign in_stall = in_vld_r && !stat.room;
  assign x        = in_byte_r[6:0];
  assign xc       = byte_cls(x);
  assign want     = (h0_r == CH_LO_L) ? CH_LO_L : CH_LO_E;

  always_comb begin
    if (x == CH_QUOTE) begin
      s_st = ST_NQ;
    end else if (x == CH_SPACE) begin
      s_st = ST_NSP;
    end else if (xc == CLS_SPACE) begin
      s_st = ST_SP1;
    end else begin
      s_st = ST_RUN;
    end
  end

  always_comb begin
    idx       = '0;
    go_start  = 1'b0;
    st_nxt    = st_r;
    h0_nxt    = h0_r;
    h1_nxt    = h1_r;
    cls_nxt   = cls_r;
    latch_nxt = latch_r;
    for (int i = 0; i < MaxPush; i++) begin
      push_d[i] = '0;
    end
    if (latch_r) begin
      if (in_last_r) begin
        latch_nxt = 1'b0;
      end
    end else if (in_byte_r[7]) begin
      st_nxt              = ST_EMPTY;
      latch_nxt           = !in_last_r;
      push_d[0].bad_input = 1'b1;
      idx                 = 2'd1;
    end else begin
      case (st_r)
        ST_EMPTY: begin
          go_start = 1'b1;
        end
        ST_RUN: begin
          push_d[idx] = mk(h0_r, xc != cls_r);
          idx = idx + 2'd1;
          if (xc == cls_r) begin
            h0_nxt = x;
          end else begin
            go_start = 1'b1;
          end
        end
        ST_SP1: begin
          if (xc == CLS_SPACE) begin
            st_nxt = ST_SP2;
            h1_nxt = x;
          end else begin
            push_d[idx] = mk(h0_r, 1'b1);
            idx = idx + 2'd1;
            go_start = 1'b1;
          end
        end
        ST_SP2: begin
          if (xc == CLS_SPACE) begin
            push_d[idx] = mk(h0_r, 1'b0);
            idx = idx + 2'd1;
            h0_nxt = h1_r;
            h1_nxt = x;
          end else begin
            push_d[idx] = mk(h0_r, 1'b1);
            idx = idx + 2'd1;
            if (h1_r == CH_SPACE) begin
              push_d[idx] = mk(CH_SPACE, 1'b0);
              idx = idx + 2'd1;
              st_nxt  = ST_RUN;
              h0_nxt  = x;
              cls_nxt = xc;
            end else begin
              push_d[idx] = mk(h1_r, 1'b1);
              idx = idx + 2'd1;
              go_start = 1'b1;
            end
          end
        end
        ST_NSP: begin
          if (xc == CLS_SPACE) begin
            st_nxt = ST_SP2;
            h0_nxt = CH_SPACE;
            h1_nxt = x;
          end else begin
            push_d[idx] = mk(CH_SPACE, 1'b0);
            idx = idx + 2'd1;
            st_nxt  = ST_RUN;
            h0_nxt  = x;
            cls_nxt = xc;
          end
        end
        ST_NQ: begin
          if (x == CH_LO_S || x == CH_LO_T || x == CH_LO_M || x == CH_LO_D) begin
            push_d[idx] = mk(CH_QUOTE, 1'b0);
            idx = idx + 2'd1;
            push_d[idx] = mk(x, 1'b1);
            idx = idx + 2'd1;
            st_nxt = ST_EMPTY;
          end else if (x == CH_LO_R || x == CH_LO_V || x == CH_LO_L) begin
            st_nxt = ST_NQR;
            h0_nxt = x;
          end else begin
            push_d[idx] = mk(CH_QUOTE, xc != CLS_SYMBOL);
            idx = idx + 2'd1;
            if (xc == CLS_SYMBOL) begin
              st_nxt  = ST_RUN;
              h0_nxt  = x;
              cls_nxt = CLS_SYMBOL;
            end else begin
              go_start = 1'b1;
            end
          end
        end
        ST_NQR: begin
          if (x == want) begin
            push_d[idx] = mk(CH_QUOTE, 1'b0);
            idx = idx + 2'd1;
            push_d[idx] = mk(h0_r, 1'b0);
            idx = idx + 2'd1;
            push_d[idx] = mk(x, 1'b1);
            idx = idx + 2'd1;
            st_nxt = ST_EMPTY;
          end else begin
            push_d[idx] = mk(CH_QUOTE, 1'b1);
            idx = idx + 2'd1;
            push_d[idx] = mk(h0_r, xc != CLS_LETTER);
            idx = idx + 2'd1;
            if (xc == CLS_LETTER) begin
              st_nxt  = ST_RUN;
              h0_nxt  = x;
              cls_nxt = CLS_LETTER;
            end else begin
              go_start = 1'b1;
            end
          end
        end
        default: begin
          go_start = 1'b1;
        end
      endcase
      if (go_start) begin
        st_nxt  = s_st;
        h0_nxt  = x;
        cls_nxt = xc;
      end
      if (in_last_r) begin
        case (st_nxt)
          ST_RUN, ST_SP1: begin
            push_d[idx] = mk(h0_nxt, 1'b1);
            idx = idx + 2'd1;
          end
          ST_SP2: begin
            push_d[idx] = mk(h0_nxt, 1'b0);
            idx = idx + 2'd1;
            push_d[idx] = mk(h1_nxt, 1'b1);
            idx = idx + 2'd1;
          end
          ST_NSP: begin
            push_d[idx] = mk(CH_SPACE, 1'b1);
            idx = idx + 2'd1;
          end
          ST_NQ: begin
            push_d[idx] = mk(CH_QUOTE, 1'b1);
            idx = idx + 2'd1;
          end
          ST_NQR: begin
            push_d[idx] = mk(CH_QUOTE, 1'b1);
            idx = idx + 2'd1;
            push_d[idx] = mk(h0_nxt, 1'b1);
            idx = idx + 2'd1;
          end
          default: begin
          end
        endcase
        st_nxt = ST_EMPTY;
      end
    end
    if (idx != '0) begin
      push_d[idx - 2'd1].batch_last = 1'b1;
    end
    push_n = fire ? idx : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_EMPTY;
      latch_r  <= 1'b0;
      in_vld_r <= 1'b0;
    end else begin
      if (fire) begin
        st_r    <= st_nxt;
        latch_r <= latch_nxt;
      end
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_text_byte;
      in_last_r <= in_text_last;
    end
    if (fire) begin
      h0_r  <= h0_nxt;
      h1_r  <= h1_nxt;
      cls_r <= cls_nxt;
    end
  end

  abpt_resq u_resq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push_d (push_d),
    .pop    (out_valid && !out_stall),
    .head   (head),
    .stat   (stat)
  );

  assign out_valid      = stat.avail;
  assign out_byte       = head.data;
  assign out_tok_end    = head.tok_end;
  assign out_bad_input  = head.bad_input;
  assign out_batch_last = head.batch_last;

endmodule

// File: hdl/abpt_chk.sv
// Port-level checker for the pre-tokenizer, bound to the top level.
`timescale 1ns / 1ps

module abpt_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_byte,
  input logic       out_tok_end,
  input logic       out_bad_input,
  input logic       out_batch_last
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("queue or input stage not empty after reset");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_byte == 7'd0 && !out_tok_end)
    else $error("reject word carries byte data");

  a_bad_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_input |-> out_batch_last)
    else $error("reject word not alone in its batch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_tok_end)
      && $stable(out_bad_input) && $stable(out_batch_last))
    else $error("stalled result word changed");

endmodule

bind ascii_bpe_pretokenizer_unit abpt_chk u_abpt_chk (.*);

// File: sim/ascii_bpe_pretokenizer_unit_chk.sv
// Channel monitor for the pre-tokenizer: predicts result words and compares them.
`timescale 1ns / 1ps

module ascii_bpe_pretokenizer_unit_chk
  import abpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_text_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [6:0] out_byte,
  input  logic       out_tok_end,
  input  logic       out_bad_input,
  input  logic       out_batch_last,
  output int         errors,
  output int         pending
);

  localparam logic [6:0] K_QUOTE = 7'h27;
  localparam logic [6:0] K_SPACE = 7'h20;
  localparam logic [6:0] K_S     = 7'h73;
  localparam logic [6:0] K_T     = 7'h74;
  localparam logic [6:0] K_M     = 7'h6d;
  localparam logic [6:0] K_D     = 7'h64;
  localparam logic [6:0] K_R     = 7'h72;
  localparam logic [6:0] K_V     = 7'h76;
  localparam logic [6:0] K_L     = 7'h6c;
  localparam logic [6:0] K_E     = 7'h65;
  localparam int         StepMax = 4;
  localparam int         RedoMax = 8;

  logic [6:0] held_chars [3];
  int         held_cnt;
  logic       in_run;
  cls_t       run_kind;
  logic       reject;
  logic [6:0] redo_stack [RedoMax];
  int         redo_n;
  res_t       step_out [StepMax];
  int         step_n;
  res_t       piece_q [$];
  res_t       want;

  function automatic cls_t char_kind(input logic [6:0] b);
    if ((b >= 7'h41 && b <= 7'h5a) || (b >= 7'h61 && b <= 7'h7a)) return CLS_LETTER;
    if (b >= 7'h30 && b <= 7'h39) return CLS_DIGIT;
    if (b == K_SPACE || (b >= 7'h09 && b <= 7'h0d)) return CLS_SPACE;
    return CLS_SYMBOL;
  endfunction

  task automatic emit_char(input logic [6:0] b, input logic ends_piece);
    if (step_n < StepMax) begin
      step_out[step_n] = {b, ends_piece, 1'b0, 1'b0};
      step_n++;
    end
  endtask

  task automatic redo_push(input logic [6:0] b);
    if (redo_n < RedoMax) begin
      redo_stack[redo_n] = b;
      redo_n++;
    end
  endtask

  task automatic redo_from(input int k);
    int i;
    for (i = held_cnt - 1; i >= k; i--) begin
      if (i < 3) redo_push(held_chars[i]);
    end
    held_cnt = 0;
  endtask

  task automatic open_run(input logic [6:0] b, input int k);
    redo_from(k);
    held_chars[0] = b;
    held_cnt = 1;
    run_kind = char_kind(b);
    in_run = 1'b1;
  endtask

  task automatic start_decide(input logic at_end);
    logic [6:0] p0;
    logic [6:0] p1;
    logic [6:0] tail;
    if (held_cnt == 0) return;
    p0 = held_chars[0];
    if (p0 == K_QUOTE) begin
      if (held_cnt < 2) begin
        if (!at_end) return;
      end else begin
        p1 = held_chars[1];
        tail = 7'h00;
        if (p1 == K_S || p1 == K_T || p1 == K_M || p1 == K_D) begin
          emit_char(p0, 1'b0);
          emit_char(p1, 1'b1);
          redo_from(2);
          return;
        end
        if (p1 == K_R || p1 == K_V) tail = K_E;
        if (p1 == K_L) tail = K_L;
        if (tail != 7'h00) begin
          if (held_cnt < 3) begin
            if (!at_end) return;
          end else if (held_chars[2] == tail) begin
            emit_char(p0, 1'b0);
            emit_char(p1, 1'b0);
            emit_char(tail, 1'b1);
            redo_from(3);
            return;
          end
        end
      end
      open_run(p0, 1);
      return;
    end
    if (p0 == K_SPACE) begin
      if (held_cnt < 2) begin
        if (!at_end) return;
        open_run(p0, 1);
        return;
      end
      if (char_kind(held_chars[1]) != CLS_SPACE) begin
        emit_char(p0, 1'b0);
        open_run(held_chars[1], 2);
        return;
      end
    end
    open_run(p0, 1);
  endtask

  task automatic feed_char(input logic [6:0] x);
    cls_t c;
    c = char_kind(x);
    if (in_run && run_kind != CLS_SPACE) begin
      if (held_cnt == 0) begin
        in_run = 1'b0;
        redo_push(x);
      end else if (c == run_kind) begin
        emit_char(held_chars[0], 1'b0);
        held_chars[0] = x;
      end else begin
        emit_char(held_chars[0], 1'b1);
        in_run = 1'b0;
        held_cnt = 0;
        redo_push(x);
      end
      return;
    end
    if (in_run) begin
      if (c == CLS_SPACE) begin
        if (held_cnt < 2) begin
          held_chars[held_cnt] = x;
          held_cnt++;
        end else begin
          emit_char(held_chars[0], 1'b0);
          held_chars[0] = held_chars[1];
          held_chars[1] = x;
        end
      end else begin
        redo_push(x);
        if (held_cnt >= 2) begin
          emit_char(held_chars[0], 1'b1);
          redo_push(held_chars[1]);
        end else if (held_cnt == 1) begin
          emit_char(held_chars[0], 1'b1);
        end
        in_run = 1'b0;
        held_cnt = 0;
      end
      return;
    end
    if (held_cnt < 3) begin
      held_chars[held_cnt] = x;
      held_cnt++;
    end
    start_decide(1'b0);
  endtask

  task automatic predict_word(input logic [7:0] tb, input logic tl);
    int i;
    int guard;
    step_n = 0;
    redo_n = 0;
    if (reject) begin
      if (tl) reject = 1'b0;
      return;
    end
    if (tb[7]) begin
      held_cnt = 0;
      in_run = 1'b0;
      reject = !tl;
      piece_q.insert(piece_q.size(), res_t'({7'h00, 1'b0, 1'b1, 1'b1}));
      return;
    end
    redo_push(tb[6:0]);
    for (guard = 0; guard < 16; guard++) begin
      while (redo_n > 0) begin
        redo_n--;
        feed_char(redo_stack[redo_n]);
      end
      if (!tl) break;
      if (!in_run) begin
        if (held_cnt == 0) break;
        start_decide(1'b1);
        continue;
      end
      for (i = 0; i < held_cnt && i < 3; i++) emit_char(held_chars[i], i + 1 == held_cnt);
      held_cnt = 0;
      in_run = 1'b0;
      break;
    end
    for (i = 0; i < step_n; i++) begin
      if (i == step_n - 1) step_out[i].batch_last = 1'b1;
      piece_q.insert(piece_q.size(), step_out[i]);
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_cnt = 0;
      in_run = 1'b0;
      run_kind = CLS_LETTER;
      reject = 1'b0;
      redo_n = 0;
      step_n = 0;
      piece_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (piece_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected word, expected none, actual byte 0x%0h end %0b bad %0b last %0b",
                   $time, out_byte, out_tok_end, out_bad_input, out_batch_last);
        end else begin
          want = piece_q.pop_front();
          check_field("out_byte", want.data, out_byte);
          check_field("out_tok_end", want.tok_end, out_tok_end);
          check_field("out_bad_input", want.bad_input, out_bad_input);
          check_field("out_batch_last", want.batch_last, out_batch_last);
        end
      end
      if (in_valid && !in_stall) predict_word(in_text_byte, in_text_last);
    end
    pending = piece_q.size();
  end

endmodule

// File: sim/ascii_bpe_pretokenizer_unit_tb.sv
// Testbench top for the pre-tokenizer: clock, reset, text stimulus, result stalls, verdict.
`timescale 1ns / 1ps

module ascii_bpe_pretokenizer_unit_tb;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_word_t;

  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_EVERY4
  } rx_mode_t;

  localparam int RandWords = 310;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_text_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_byte;
  logic       out_tok_end;
  logic       out_bad_input;
  logic       out_batch_last;
  int         errors;
  int         pending;

  text_word_t stim_q [$];
  logic [7:0] txt [$];

  always #4 clk = ~clk;

  ascii_bpe_pretokenizer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_text_last  (in_text_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_tok_end   (out_tok_end),
    .out_bad_input (out_bad_input),
    .out_batch_last(out_batch_last)
  );

  ascii_bpe_pretokenizer_unit_chk chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_text_last  (in_text_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_tok_end   (out_tok_end),
    .out_bad_input (out_bad_input),
    .out_batch_last(out_batch_last),
    .errors        (errors),
    .pending       (pending)
  );

  task automatic put_byte(input logic [7:0] b);
    txt.insert(txt.size(), b);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic end_text();
    for (int i = 0; i < txt.size(); i++) begin
      stim_q.insert(stim_q.size(), text_word_t'({txt[i], i == txt.size() - 1}));
    end
    txt.delete();
  endtask

  initial begin
    string      syms;
    string      tails [14];
    int         n_dir;
    int         n_tok;
    int         len;
    int         pick;
    int         idx;
    int         burst;
    int         gap;
    logic       mid_paused;
    logic [7:0] ch;

    syms = "!\"#$%&()*+,-./:;<=>?@[\\]^_`{|}~";
    tails = '{"s", "t", "re", "ve", "m", "ll", "d", "r", "v", "l", "lx", "ra", "S", "x"};

    put_str("x's'll'd'r");
    end_text();
    put_str(" 9\t z");
    end_text();
    put_str("'");
    end_text();
    put_byte(8'h00);
    put_byte(8'h7f);
    end_text();
    put_str("ab");
    put_byte(8'hff);
    put_str("cd");
    end_text();
    put_byte(8'h80);
    end_text();
    put_str("  ");
    end_text();
    n_dir = stim_q.size();

    while (stim_q.size() < n_dir + RandWords) begin
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) begin
        pick = $urandom_range(0, 99);
        if (pick < 52 && $urandom_range(0, 1) == 1) put_byte(8'h20);
        if (pick < 30) begin
          len = $urandom_range(1, 6);
          repeat (len) begin
            ch = 8'(($urandom_range(0, 3) == 0 ? 8'h41 : 8'h61) + $urandom_range(0, 25));
            put_byte(ch);
          end
        end else if (pick < 42) begin
          len = $urandom_range(1, 4);
          repeat (len) begin
            ch = 8'(8'h30 + $urandom_range(0, 9));
            put_byte(ch);
          end
        end else if (pick < 52) begin
          len = $urandom_range(1, 3);
          repeat (len) begin
            if ($urandom_range(0, 4) == 0) begin
              ch = 8'($urandom_range(0, 19));
              if (ch >= 8'h09) ch = ch + 8'h05;
              if (ch == 8'h13) ch = 8'h7f;
            end else begin
              ch = syms[$urandom_range(0, syms.len() - 1)];
            end
            put_byte(ch);
          end
        end else if (pick < 70) begin
          put_byte(8'h27);
          put_str(tails[$urandom_range(0, 9) < 7 ? $urandom_range(0, 6) : $urandom_range(7, 13)]);
        end else if (pick < 85) begin
          len = $urandom_range(1, 3);
          repeat (len) begin
            ch = 8'(($urandom_range(0, 4) < 3) ? 8'h20 : 8'h09 + $urandom_range(0, 4));
            put_byte(ch);
          end
        end else if (pick < 89) begin
          put_byte(8'h27);
        end else if (pick < 96) begin
          ch = 8'($urandom_range(0, 127));
          put_byte(ch);
        end else begin
          ch = 8'($urandom_range(128, 255));
          put_byte(ch);
        end
      end
      end_text();
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    idx = 0;
    mid_paused = 1'b0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        in_valid <= 1'b1;
        in_text_byte <= stim_q[idx].ch;
        in_text_last <= stim_q[idx].last;
        do @(posedge clk); while (in_stall);
        burst--;
        idx++;
        if (stim_q[idx - 1].last && (idx == n_dir || (!mid_paused && idx >= n_dir + 150))) begin
          if (idx != n_dir) mid_paused = 1'b1;
          in_valid <= 1'b0;
          @(negedge clk);
          while (pending != 0) @(negedge clk);
          @(posedge clk);
        end
      end
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ascii_bpe_pretokenizer_unit_tb: done, clean");
    end else begin
      $display("ascii_bpe_pretokenizer_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    int       cyc;
    rx_mode_t mode;
    cyc = 0;
    mode = RX_FREE;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 40 == 0) mode = rx_mode_t'($urandom_range(0, 3));
      if (cyc == 150 || cyc == 300 || cyc == 700) begin
        out_stall <= 1'b1;
        repeat (100) @(posedge clk);
        cyc += 100;
      end else begin
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 99) < 30);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 99) < 75);
          default:   out_stall <= (cyc % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    #400000;
    $display("ascii_bpe_pretokenizer_unit_tb: done, errors");
    $finish;
  end

endmodule
